/* hw/rtl/csvft_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package csvft_pkg;

  localparam int unsigned MAX_PENDING_DEF = 32;

  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DECIDE = 4'b0010,
    ST_FLUSH  = 4'b0100,
    ST_BYTE   = 4'b1000
  } state_t;

  // one result, flags packed lowest first after the byte
  typedef struct packed {
    logic       dropped;
    logic       row_end;
    logic       field_end;
    logic       is_content;
    logic [7:0] data;
  } res_t;

  typedef struct packed {
    logic load;         // latch the accepted item
    logic commit;       // apply the decided state update
    logic start_flush;  // rewind the held-blank read pointer
    logic emit_blank;   // send the held blank at the read pointer
    logic emit_byte;    // send the item byte after the held blanks
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_flush;   // content byte with blanks still held
    logic need_out;     // decided update sends one result
    logic out_free;     // output register can take a result
    logic flush_last;   // read pointer is on the last held blank
  } dp_status_t;

endpackage

`default_nettype wire

/* hw/rtl/csvft_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module csvft_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_tvalid,
  output logic                    in_tready,
  input  csvft_pkg::dp_status_t   sts,
  output csvft_pkg::ctrl_cmd_t    cmd
);

  csvft_pkg::state_t state_r;
  csvft_pkg::state_t state_nxt;

  assign in_tready = (state_r == csvft_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      csvft_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = csvft_pkg::ST_DECIDE;
        end
      end
      csvft_pkg::ST_DECIDE: begin
        if (sts.need_flush) begin
          cmd.commit      = 1'b1;
          cmd.start_flush = 1'b1;
          state_nxt       = csvft_pkg::ST_FLUSH;
        end else if (!sts.need_out || sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = csvft_pkg::ST_IDLE;
        end
      end
      csvft_pkg::ST_FLUSH: begin
        if (sts.out_free) begin
          cmd.emit_blank = 1'b1;
          if (sts.flush_last) begin
            state_nxt = csvft_pkg::ST_BYTE;
          end
        end
      end
      csvft_pkg::ST_BYTE: begin
        if (sts.out_free) begin
          cmd.emit_byte = 1'b1;
          state_nxt     = csvft_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = csvft_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csvft_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/csvft_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module csvft_dp #(
  parameter int unsigned MAX_PENDING = csvft_pkg::MAX_PENDING_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire  [7:0]              in_tdata,
  input  wire                     in_tuser,
  input  csvft_pkg::ctrl_cmd_t    cmd,
  output csvft_pkg::dp_status_t   sts,
  output logic                    out_tvalid,
  input  wire                     out_tready,
  output logic [7:0]              out_tdata,
  output logic [3:0]              out_tuser,
  output logic                    out_tlast
);

  localparam int CW = $clog2(MAX_PENDING + 1);
  localparam int AW = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;

  // latched item
  logic [7:0]    byte_r;
  logic          eoi_r;

  // tokenizer state
  logic          iq_r, iq_nxt;
  logic          qs_r, qs_nxt;
  logic          fhc_r, fhc_nxt;
  logic          rnb_r, rnb_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // held blanks: 1 = tab, 0 = space
  logic          held_mem [MAX_PENDING];
  logic          rd_bit_r;
  logic [AW-1:0] idx_r;
  logic [AW-1:0] rd_addr;

  logic                 out_valid_r;
  csvft_pkg::res_t      out_res_r;
  logic                 out_last_r;

  logic                 is_blank;
  logic                 to_field;
  logic                 wr_en;
  logic                 emit_one;
  logic                 flush;
  csvft_pkg::res_t      dec_res;
  logic                 out_free;
  logic                 out_load;
  csvft_pkg::res_t      load_res;
  logic                 load_last;

  always_comb begin
    is_blank = (byte_r == csvft_pkg::CHAR_SPACE) || (byte_r == csvft_pkg::CHAR_TAB);
    iq_nxt   = iq_r;
    qs_nxt   = qs_r;
    fhc_nxt  = fhc_r;
    rnb_nxt  = rnb_r;
    cnt_nxt  = cnt_r;
    wr_en    = 1'b0;
    emit_one = 1'b0;
    flush    = 1'b0;
    to_field = 1'b0;
    dec_res  = '0;
    if (eoi_r || byte_r == csvft_pkg::CHAR_NL) begin
      // row end; a blank row sends nothing
      emit_one          = rnb_r;
      dec_res.field_end = 1'b1;
      dec_res.row_end   = 1'b1;
      iq_nxt  = 1'b0;
      qs_nxt  = 1'b0;
      fhc_nxt = 1'b0;
      rnb_nxt = 1'b0;
      cnt_nxt = '0;
    end else begin
      if (!(is_blank || byte_r == csvft_pkg::CHAR_CR)) begin
        rnb_nxt = 1'b1;
      end
      if (iq_r && qs_r && byte_r == csvft_pkg::CHAR_QUOTE) begin
        // doubled quote gives one literal quote
        qs_nxt   = 1'b0;
        to_field = 1'b1;
      end else if (iq_r && !qs_r) begin
        if (byte_r == csvft_pkg::CHAR_QUOTE) begin
          qs_nxt = 1'b1;
        end else begin
          to_field = 1'b1;
        end
      end else begin
        // unquoted, also the byte after a closing quote
        iq_nxt = 1'b0;
        qs_nxt = 1'b0;
        if (byte_r == csvft_pkg::CHAR_QUOTE) begin
          iq_nxt = 1'b1;
        end else if (byte_r == csvft_pkg::CHAR_COMMA) begin
          emit_one          = 1'b1;
          dec_res.field_end = 1'b1;
          fhc_nxt           = 1'b0;
          cnt_nxt           = '0;
        end else if (byte_r != csvft_pkg::CHAR_CR) begin
          to_field = 1'b1;
        end
      end
      if (to_field) begin
        if (is_blank) begin
          if (fhc_r) begin
            if (cnt_r < CW'(MAX_PENDING)) begin
              wr_en   = 1'b1;
              cnt_nxt = cnt_r + CW'(1);
            end else begin
              emit_one        = 1'b1;
              dec_res.dropped = 1'b1;
            end
          end
        end else if (cnt_r != '0) begin
          flush = 1'b1;
        end else begin
          emit_one           = 1'b1;
          dec_res.is_content = 1'b1;
          dec_res.data       = byte_r;
          fhc_nxt            = 1'b1;
        end
      end
    end
  end

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    sts.need_flush = flush;
    sts.need_out   = emit_one;
    sts.out_free   = out_free;
    sts.flush_last = (cnt_r == (CW'(idx_r) + CW'(1)));
  end

  always_comb begin
    if (cmd.start_flush) begin
      rd_addr = '0;
    end else if (cmd.emit_blank) begin
      rd_addr = idx_r + AW'(1);
    end else begin
      rd_addr = idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      held_mem[cnt_r[AW-1:0]] <= (byte_r == csvft_pkg::CHAR_TAB);
    end
    rd_bit_r <= held_mem[rd_addr];
  end

  always_comb begin
    out_load  = (cmd.commit && emit_one) || cmd.emit_blank || cmd.emit_byte;
    load_res  = '0;
    load_last = 1'b1;
    if (cmd.emit_blank) begin
      load_res.is_content = 1'b1;
      load_res.data       = rd_bit_r ? csvft_pkg::CHAR_TAB : csvft_pkg::CHAR_SPACE;
      load_last           = 1'b0;
    end else if (cmd.emit_byte) begin
      load_res.is_content = 1'b1;
      load_res.data       = byte_r;
    end else begin
      load_res = dec_res;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= in_tdata;
      eoi_r  <= in_tuser;
    end
    if (out_load) begin
      out_res_r  <= load_res;
      out_last_r <= load_last;
    end
    if (cmd.start_flush) begin
      idx_r <= '0;
    end else if (cmd.emit_blank) begin
      idx_r <= idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iq_r        <= 1'b0;
      qs_r        <= 1'b0;
      fhc_r       <= 1'b0;
      rnb_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        iq_r  <= iq_nxt;
        qs_r  <= qs_nxt;
        rnb_r <= rnb_nxt;
        if (!flush) begin
          fhc_r <= fhc_nxt;
          cnt_r <= cnt_nxt;
        end
      end else if (cmd.emit_byte) begin
        cnt_r <= '0;
        fhc_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.data;
  assign out_tuser  = {out_res_r.dropped, out_res_r.row_end,
                       out_res_r.field_end, out_res_r.is_content};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_PENDING))
    else $error("held blank count beyond limit");

  a_blank_needs_content: assert property (@(posedge clk) disable iff (!rst_n)
    !fhc_r |-> cnt_r == '0)
    else $error("blanks held in a field without content");

  a_quote_seen_quoted: assert property (@(posedge clk) disable iff (!rst_n)
    qs_r |-> iq_r)
    else $error("pending quote outside quoted mode");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot({out_res_r.is_content, out_res_r.field_end, out_res_r.dropped}))
    else $error("result carries no single kind");

  a_row_end_field_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.row_end |-> out_res_r.field_end)
    else $error("row end without field end");
`endif

endmodule

`default_nettype wire

/* hw/rtl/csv_field_tokenizer.sv */
// CSV field tokenizer.
// in_*: one transfer per raw text byte; in_tuser set means end of input (flush the
//   final row, in_tdata ignored).
// out_*: one transfer per result: a content byte, a field end (with row end for the
//   last field of a row), or a note that an overflowing held blank was discarded.
//   out_tlast marks the final result caused by an input transfer; an input that
//   causes no result gives no output transfer.
// Fields are trimmed of leading and trailing spaces and tabs; inner blanks are held
//   in a small memory and replayed before the next content byte.
// Flow: an item is taken in the idle state and decided in the next cycle, waiting
//   there while a result is due and the output is not free. A content byte after
//   held blanks first replays them, one per cycle from the held-blank memory while
//   the output is free, then sends the byte. Only one item is in work at a time.
// The output register decouples the sides: a new item is accepted while the last
//   result still waits; a stalled receiver holds the block in its decide or replay
//   step until the register frees.
// Reset (rst_n low, synchronous) clears quote state, row state and the held count;
//   the held-blank memory is not cleared since entries are read only after writing.
`timescale 1ns / 1ps
`default_nettype none

module csv_field_tokenizer #(
  parameter int unsigned MAX_PENDING = csvft_pkg::MAX_PENDING_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire  [7:0] in_tdata,   // [7:0] in_byte
  input  wire        in_tuser,   // [0] end_of_input
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [3:0] out_tuser,  // [0] is_content [1] field_end [2] row_end
                                 // [3] whitespace_dropped
  output logic       out_tlast   // last_of_run
);

  csvft_pkg::ctrl_cmd_t  cmd;
  csvft_pkg::dp_status_t sts;

  csvft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  csvft_dp #(
    .MAX_PENDING (MAX_PENDING)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
